@@ design/sir_pkg.sv @@
package sir_pkg;

    localparam int POP_W   = 32;
    localparam int WIDE_W  = 48;
    localparam int RATE_W  = 40;
    localparam int GAMMA_W = 24;
    localparam int SUM_W   = 56;
    localparam int ACC_W   = 96;
    localparam int CHUNK_W = 16;
    localparam int NCHUNK  = 3;
    localparam int IDX_W   = 3;
    localparam int NIB_W   = 4;
    localparam int NSTEP   = SUM_W / NIB_W;

    typedef enum logic [1:0] {
        SH_12,
        SH_16,
        SH_24,
        SH_40
    } shift_sel_t;

    typedef logic signed [SUM_W-1:0] sum_t;

    localparam logic [IDX_W-1:0] REG_INFECTION = 3'd0;
    localparam logic [IDX_W-1:0] REG_RECOVERY  = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP      = 3'd2;
    localparam logic [IDX_W-1:0] REG_END       = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_S   = 3'd4;
    localparam logic [IDX_W-1:0] REG_START_I   = 3'd5;
    localparam logic [IDX_W-1:0] REG_START_R   = 3'd6;

    localparam logic [POP_W-1:0] TIME_STEP_RESET = 32'h0001_0000;

    // Clamps a signed value to the unsigned population range.
    function automatic logic [POP_W:0] clamp_pop(input sum_t v);
        logic [POP_W:0] r;
        if (v < 0) begin
            r = {1'b1, {POP_W{1'b0}}};
        end else if (v > sum_t'({POP_W{1'b1}})) begin
            r = {1'b1, {POP_W{1'b1}}};
        end else begin
            r = {1'b0, v[POP_W-1:0]};
        end
        return r;
    endfunction

endpackage

@@ design/sir_mul.sv @@
module sir_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sir_pkg::WIDE_W-1:0]   a,
    input  logic [sir_pkg::RATE_W-1:0]   b,
    input  sir_pkg::shift_sel_t          shift_sel,
    output logic                         done,
    output logic [sir_pkg::WIDE_W-1:0]   result
);
    import sir_pkg::*;

    localparam int CNT_W = $clog2(NCHUNK);

    logic [WIDE_W-1:0]          a_reg;
    logic [NCHUNK*CHUNK_W-1:0]  b_reg;
    shift_sel_t                 sel_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [CHUNK_W-1:0]         chunk;
    logic [WIDE_W+CHUNK_W-1:0]  prod;
    logic [ACC_W-1:0]           prod_shifted;
    logic [ACC_W-1:0]           round_init;
    logic [ACC_W-1:0]           shifted;

    assign chunk        = b_reg[cnt_reg*CHUNK_W +: CHUNK_W];
    assign prod         = a_reg * chunk;
    assign prod_shifted = ACC_W'(prod) << (cnt_reg * CHUNK_W);

    always_comb
    begin
        case (shift_sel)
            SH_12:   round_init = ACC_W'(1) << 11;
            SH_16:   round_init = ACC_W'(1) << 15;
            SH_24:   round_init = ACC_W'(1) << 23;
            default: round_init = ACC_W'(1) << 39;
        endcase
    end

    always_comb
    begin
        case (sel_reg)
            SH_12:   shifted = acc_reg >> 12;
            SH_16:   shifted = acc_reg >> 16;
            SH_24:   shifted = acc_reg >> 24;
            default: shifted = acc_reg >> 40;
        endcase
    end

    assign result = (|shifted[ACC_W-1:WIDE_W]) ? {WIDE_W{1'b1}} : shifted[WIDE_W-1:0];
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(NCHUNK - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= (NCHUNK*CHUNK_W)'(b);
            sel_reg <= shift_sel;
            acc_reg <= round_init;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + prod_shifted;
        end
    end

endmodule

@@ design/sir_div6.sv @@
module sir_div6 (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [2:0][sir_pkg::SUM_W-1:0]        sums,
    output logic                                  done,
    output logic [2:0][sir_pkg::SUM_W-1:0]        quots
);
    import sir_pkg::*;

    localparam int STEP_W = $clog2(NSTEP);

    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    function automatic logic [NIB_W+2:0] div6_nib(input logic [2:0] rem,
                                                  input logic [NIB_W-1:0] nib);
        logic [3:0]       r;
        logic [NIB_W-1:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int k = NIB_W - 1; k >= 0; k--) begin
            r = {r[2:0], nib[k]};
            q = {q[NIB_W-2:0], 1'b0};
            if (r >= 4'd6) begin
                r    = r - 4'd6;
                q[0] = 1'b1;
            end
        end
        return {q, r[2:0]};
    endfunction

    for (genvar ln = 0; ln < 3; ln++) begin : g_lane
        logic [SUM_W-1:0] mag_reg;
        logic [SUM_W-1:0] q_reg;
        logic [2:0]       rem_reg;
        logic             neg_reg;
        logic [NIB_W+2:0] nib_out;
        sum_t             s_in;
        logic [SUM_W-1:0] mag_in;

        assign s_in    = sums[ln];
        assign mag_in  = (s_in < 0 ? SUM_W'(-s_in) : SUM_W'(s_in)) + SUM_W'(3);
        assign nib_out = div6_nib(rem_reg, mag_reg[SUM_W-1 -: NIB_W]);
        assign quots[ln] = neg_reg ? SUM_W'(-q_reg) : q_reg;

        always_ff @(posedge clk)
        begin
            if (start) begin
                mag_reg <= mag_in;
                q_reg   <= '0;
                rem_reg <= '0;
                neg_reg <= s_in < 0;
            end else if (busy_reg) begin
                mag_reg <= mag_reg << NIB_W;
                q_reg   <= {q_reg[SUM_W-NIB_W-1:0], nib_out[NIB_W+2:3]};
                rem_reg <= nib_out[2:0];
            end
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_W'(NSTEP - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

endmodule

@@ design/sir_epidemic_rk4_step.sv @@
// SIR epidemic integrator, one fourth-order Runge-Kutta step per item.
// Configuration is written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, and registers may be written only
// while no item is in flight.
// An input item carries restart. A restart item loads the start populations
// and time zero and emits that row. A step item advances the state by one
// step, or repeats the row once time has passed end_time.
// Each item produces exactly one result item on the output channel.
// A step runs four stages of five products each on one shared 48x16
// multiplier, each product built from three partial products, plus one
// accumulate state per stage; the divide by six in three lanes and the
// emit state follow. A new item is accepted only after the emit state has
// passed the result to the output register. Restart and past-end items
// skip the multiplier and divider and go straight to the emit state.
// in_stall is high while an item is being worked on, including while the
// emit state waits on a stalled result.
// The result sits in an output register; a new item is accepted while it
// waits, and the block holds its result until out_stall drops.
// Reset clears the state to zero, sets time_step to one and clears the other
// configuration registers; no result is pending after reset.
module sir_epidemic_rk4_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sir_pkg::IDX_W-1:0]      cfg_index,
    input  logic [sir_pkg::RATE_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sir_pkg::POP_W-1:0]      time_now,
    output logic [sir_pkg::POP_W-1:0]      susceptible_now,
    output logic [sir_pkg::POP_W-1:0]      infected_now,
    output logic [sir_pkg::POP_W-1:0]      recovered_now,
    output logic                           final_row,
    output logic                           clamped
);
    import sir_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_ACCUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_P,
        OP_INFL,
        OP_RECV,
        OP_DINF,
        OP_DREC
    } op_t;

    state_t state_reg;
    op_t    op_reg;
    logic [1:0] stage_reg;

    logic [RATE_W-1:0]  infection_rate_reg;
    logic [GAMMA_W-1:0] recovery_rate_reg;
    logic [POP_W-1:0]   time_step_reg;
    logic [POP_W-1:0]   end_time_reg;
    logic [POP_W-1:0]   start_s_reg;
    logic [POP_W-1:0]   start_i_reg;
    logic [POP_W-1:0]   start_r_reg;

    logic [POP_W-1:0]   sim_time_reg;
    logic [POP_W-1:0]   pop_s_reg;
    logic [POP_W-1:0]   pop_i_reg;
    logic [POP_W-1:0]   pop_r_reg;
    logic               fin_reg;
    logic               hit_reg;

    logic [POP_W-1:0]   stage_s_reg;
    logic [POP_W-1:0]   stage_i_reg;
    logic [WIDE_W-1:0]  p_reg;
    logic [WIDE_W-1:0]  infl_reg;
    logic [WIDE_W-1:0]  recv_reg;
    logic [WIDE_W-1:0]  dinf_reg;
    logic [WIDE_W-1:0]  drec_reg;
    sum_t               sum_s_reg;
    sum_t               sum_i_reg;
    sum_t               sum_r_reg;

    logic               out_valid_reg;
    logic [POP_W-1:0]   time_out_reg;
    logic [POP_W-1:0]   s_out_reg;
    logic [POP_W-1:0]   i_out_reg;
    logic [POP_W-1:0]   r_out_reg;
    logic               fin_out_reg;
    logic               hit_out_reg;

    logic               mul_start;
    logic [WIDE_W-1:0]  mul_a;
    logic [RATE_W-1:0]  mul_b;
    shift_sel_t         mul_sel;
    logic               mul_done;
    logic [WIDE_W-1:0]  mul_result;

    logic               div_start;
    logic               div_done;
    logic [2:0][SUM_W-1:0] div_quots;

    logic               in_accept;
    logic               out_free;

    sum_t ks, ki, kr, hs, hi;
    logic [POP_W:0] next_s, next_i;
    logic [POP_W:0] new_s, new_i, new_r;
    logic [POP_W:0] time_sum;
    logic [POP_W-1:0] time_new;

    sir_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mul_start),
        .a         (mul_a),
        .b         (mul_b),
        .shift_sel (mul_sel),
        .done      (mul_done),
        .result    (mul_result)
    );

    sir_div6 u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sums  ({sum_r_reg, sum_i_reg, sum_s_reg}),
        .done  (div_done),
        .quots (div_quots)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = state_reg != ST_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mul_start = state_reg == ST_MUL_GO;
    assign div_start = state_reg == ST_DIV_GO;

    always_comb
    begin
        case (op_reg)
            OP_P: begin
                mul_a   = WIDE_W'(stage_s_reg);
                mul_b   = RATE_W'(stage_i_reg);
                mul_sel = SH_12;
            end
            OP_INFL: begin
                mul_a   = p_reg;
                mul_b   = infection_rate_reg;
                mul_sel = SH_40;
            end
            OP_RECV: begin
                mul_a   = WIDE_W'(stage_i_reg);
                mul_b   = RATE_W'(recovery_rate_reg);
                mul_sel = SH_24;
            end
            OP_DINF: begin
                mul_a   = infl_reg;
                mul_b   = RATE_W'(time_step_reg);
                mul_sel = SH_16;
            end
            default: begin
                mul_a   = recv_reg;
                mul_b   = RATE_W'(time_step_reg);
                mul_sel = SH_16;
            end
        endcase
    end

    always_comb
    begin
        ks = -sum_t'(dinf_reg);
        ki = sum_t'(dinf_reg) - sum_t'(drec_reg);
        kr = sum_t'(drec_reg);
        if (stage_reg == 2'd2) begin
            hs = ks;
            hi = ki;
        end else begin
            hs = (ks < 0) ? -((-ks) >>> 1) : (ks >>> 1);
            hi = (ki < 0) ? -((-ki) >>> 1) : (ki >>> 1);
        end
        next_s = clamp_pop(sum_t'(pop_s_reg) + hs);
        next_i = clamp_pop(sum_t'(pop_i_reg) + hi);
        new_s  = clamp_pop(sum_t'(pop_s_reg) + sum_t'(div_quots[0]));
        new_i  = clamp_pop(sum_t'(pop_i_reg) + sum_t'(div_quots[1]));
        new_r  = clamp_pop(sum_t'(pop_r_reg) + sum_t'(div_quots[2]));
        time_sum = {1'b0, sim_time_reg} + {1'b0, time_step_reg};
        time_new = time_sum[POP_W] ? {POP_W{1'b1}} : time_sum[POP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            infection_rate_reg <= '0;
            recovery_rate_reg  <= '0;
            time_step_reg      <= TIME_STEP_RESET;
            end_time_reg       <= '0;
            start_s_reg        <= '0;
            start_i_reg        <= '0;
            start_r_reg        <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_INFECTION: infection_rate_reg <= cfg_data;
                REG_RECOVERY:  recovery_rate_reg  <= cfg_data[GAMMA_W-1:0];
                REG_STEP:      time_step_reg      <= cfg_data[POP_W-1:0];
                REG_END:       end_time_reg       <= cfg_data[POP_W-1:0];
                REG_START_S:   start_s_reg        <= cfg_data[POP_W-1:0];
                REG_START_I:   start_i_reg        <= cfg_data[POP_W-1:0];
                REG_START_R:   start_r_reg        <= cfg_data[POP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_P;
            stage_reg     <= '0;
            sim_time_reg  <= '0;
            pop_s_reg     <= '0;
            pop_i_reg     <= '0;
            pop_r_reg     <= '0;
            fin_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && !out_stall && state_reg != ST_EMIT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (restart) begin
                            sim_time_reg <= '0;
                            pop_s_reg    <= start_s_reg;
                            pop_i_reg    <= start_i_reg;
                            pop_r_reg    <= start_r_reg;
                            fin_reg      <= 1'b0;
                            hit_reg      <= 1'b0;
                            state_reg    <= ST_EMIT;
                        end else if (sim_time_reg > end_time_reg) begin
                            fin_reg   <= 1'b1;
                            hit_reg   <= 1'b0;
                            state_reg <= ST_EMIT;
                        end else begin
                            op_reg    <= OP_P;
                            stage_reg <= '0;
                            state_reg <= ST_MUL_GO;
                        end
                    end
                end
                ST_MUL_GO: begin
                    state_reg <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT: begin
                    if (mul_done) begin
                        if (op_reg == OP_DREC) begin
                            state_reg <= ST_ACCUM;
                        end else begin
                            op_reg    <= op_t'(op_reg + 3'd1);
                            state_reg <= ST_MUL_GO;
                        end
                    end
                end
                ST_ACCUM: begin
                    op_reg <= OP_P;
                    if (stage_reg == 2'd3) begin
                        state_reg <= ST_DIV_GO;
                    end else begin
                        stage_reg <= stage_reg + 2'd1;
                        state_reg <= ST_MUL_GO;
                    end
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        pop_s_reg    <= new_s[POP_W-1:0];
                        pop_i_reg    <= new_i[POP_W-1:0];
                        pop_r_reg    <= new_r[POP_W-1:0];
                        hit_reg      <= new_s[POP_W] || new_i[POP_W] || new_r[POP_W];
                        sim_time_reg <= time_new;
                        fin_reg      <= time_new > end_time_reg;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_accept) begin
            stage_s_reg <= pop_s_reg;
            stage_i_reg <= pop_i_reg;
            sum_s_reg   <= '0;
            sum_i_reg   <= '0;
            sum_r_reg   <= '0;
        end
        if (state_reg == ST_MUL_WAIT && mul_done) begin
            case (op_reg)
                OP_P:    p_reg    <= mul_result;
                OP_INFL: infl_reg <= mul_result;
                OP_RECV: recv_reg <= mul_result;
                OP_DINF: dinf_reg <= mul_result;
                default: drec_reg <= mul_result;
            endcase
        end
        if (state_reg == ST_ACCUM) begin
            if (stage_reg == 2'd1 || stage_reg == 2'd2) begin
                sum_s_reg <= sum_s_reg + (ks <<< 1);
                sum_i_reg <= sum_i_reg + (ki <<< 1);
                sum_r_reg <= sum_r_reg + (kr <<< 1);
            end else begin
                sum_s_reg <= sum_s_reg + ks;
                sum_i_reg <= sum_i_reg + ki;
                sum_r_reg <= sum_r_reg + kr;
            end
            stage_s_reg <= next_s[POP_W-1:0];
            stage_i_reg <= next_i[POP_W-1:0];
        end
        if (state_reg == ST_EMIT && out_free) begin
            time_out_reg <= sim_time_reg;
            s_out_reg    <= pop_s_reg;
            i_out_reg    <= pop_i_reg;
            r_out_reg    <= pop_r_reg;
            fin_out_reg  <= fin_reg;
            hit_out_reg  <= hit_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign time_now        = time_out_reg;
    assign susceptible_now = s_out_reg;
    assign infected_now    = i_out_reg;
    assign recovered_now   = r_out_reg;
    assign final_row       = fin_out_reg;
    assign clamped         = hit_out_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL_WAIT)
        else $error("multiplier finished outside its wait state");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_restart_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && restart |=> !fin_reg && !hit_reg && sim_time_reg == '0)
        else $error("restart row not cleared");

endmodule

@@ tb/tb_sir_epidemic_rk4_step.sv @@
module tb_sir_epidemic_rk4_step;
    timeunit 1ns;
    timeprecision 1ps;
    import sir_pkg::*;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] s;
        logic [31:0] i;
        logic [31:0] r;
        logic        fin;
        logic        clp;
    } sir_row_t;

    localparam longint unsigned CAP48 = 64'hFFFF_FFFF_FFFF;
    localparam longint POP_MAX = 64'sh0000_0000_FFFF_FFFF;
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    class sir_scoreboard;
        logic [39:0] beta;
        logic [23:0] gamma;
        logic [31:0] dt;
        logic [31:0] t_end;
        logic [31:0] s0, i0, r0;
        logic [31:0] t_cur, s_cur, i_cur, r_cur;
        sir_row_t    pending[$];
        int          errors;

        function void clear();
            beta = 0;
            gamma = 0;
            dt = TIME_STEP_RESET;
            t_end = 0;
            s0 = 0;
            i0 = 0;
            r0 = 0;
            t_cur = 0;
            s_cur = 0;
            i_cur = 0;
            r_cur = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [39:0] v);
            case (idx)
                REG_INFECTION: beta = v;
                REG_RECOVERY:  gamma = v[23:0];
                REG_STEP:      dt = v[31:0];
                REG_END:       t_end = v[31:0];
                REG_START_S:   s0 = v[31:0];
                REG_START_I:   i0 = v[31:0];
                REG_START_R:   r0 = v[31:0];
                default: ;
            endcase
        endfunction

        function longint unsigned mul_rnd(longint unsigned a, longint unsigned b, int sh);
            logic [127:0] p;
            p = 128'(a) * 128'(b) + (128'd1 << (sh - 1));
            p = p >> sh;
            return (p > CAP48) ? CAP48 : p[63:0];
        endfunction

        function void rates(longint s, longint i, output longint ks, output longint ki,
                            output longint kr);
            longint unsigned p, infl, recv, dinf, drec;
            p = mul_rnd(s, i, 12);
            infl = mul_rnd(beta, p, 40);
            recv = mul_rnd(gamma, i, 24);
            dinf = mul_rnd(infl, dt, 16);
            drec = mul_rnd(recv, dt, 16);
            ks = -longint'(dinf);
            ki = longint'(dinf) - longint'(drec);
            kr = longint'(drec);
        endfunction

        function longint clip(longint v, inout bit hit);
            if (v < 0)
            begin
                hit = 1;
                return 0;
            end
            if (v > POP_MAX)
            begin
                hit = 1;
                return POP_MAX;
            end
            return v;
        endfunction

        function longint div6(longint v);
            if (v >= 0)
                return (v + 3) / 6;
            return -((-v + 3) / 6);
        endfunction

        function void note_item(logic rs);
            sir_row_t e;
            longint ks[4], ki[4], kr[4];
            longint hs, hi, s, i;
            longint unsigned nt;
            bit hit, dummy;
            hit = 0;
            e.fin = 0;
            if (rs)
            begin
                t_cur = 0;
                s_cur = s0;
                i_cur = i0;
                r_cur = r0;
            end
            else if (t_cur > t_end)
                e.fin = 1;
            else
            begin
                s = s_cur;
                i = i_cur;
                rates(s, i, ks[0], ki[0], kr[0]);
                for (int n = 1; n < 4; n++)
                begin
                    hs = (n < 3) ? ks[n-1] / 2 : ks[n-1];
                    hi = (n < 3) ? ki[n-1] / 2 : ki[n-1];
                    dummy = 0;
                    rates(clip(s + hs, dummy), clip(i + hi, dummy), ks[n], ki[n], kr[n]);
                end
                s_cur = clip(longint'(s_cur) + div6(ks[0] + 2*ks[1] + 2*ks[2] + ks[3]), hit);
                i_cur = clip(longint'(i_cur) + div6(ki[0] + 2*ki[1] + 2*ki[2] + ki[3]), hit);
                r_cur = clip(longint'(r_cur) + div6(kr[0] + 2*kr[1] + 2*kr[2] + kr[3]), hit);
                nt = longint'(t_cur) + longint'(dt);
                t_cur = (nt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nt[31:0];
                e.fin = t_cur > t_end;
            end
            e.t = t_cur;
            e.s = s_cur;
            e.i = i_cur;
            e.r = r_cur;
            e.clp = hit;
            pending.push_back(e);
        endfunction

        function void check_row(sir_row_t a);
            sir_row_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected row t=%h", a.t);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.t !== e.t) begin $error("time_now exp %h got %h", e.t, a.t); errors++; end
            if (a.s !== e.s)
            begin
                $error("susceptible_now exp %h got %h", e.s, a.s);
                errors++;
            end
            if (a.i !== e.i) begin $error("infected_now exp %h got %h", e.i, a.i); errors++; end
            if (a.r !== e.r) begin $error("recovered_now exp %h got %h", e.r, a.r); errors++; end
            if (a.fin !== e.fin) begin $error("final_row exp %b got %b", e.fin, a.fin); errors++; end
            if (a.clp !== e.clp) begin $error("clamped exp %b got %b", e.clp, a.clp); errors++; end
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [RATE_W-1:0] cfg_data = '0;
    logic              in_valid = 0;
    logic              in_stall;
    logic              restart = 0;
    logic              out_valid;
    logic              out_stall = 1;
    logic [31:0]       time_now, susceptible_now, infected_now, recovered_now;
    logic              final_row, clamped;
    sir_scoreboard     sb;

    sir_epidemic_rk4_step dut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [39:0] v);
        cfg_index = idx;
        cfg_data = v;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic send_item(logic rs);
        int gap;
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
        repeat (gap) @(negedge clk);
        restart = rs;
        in_valid = 1;
        do @(posedge clk); while (in_stall);
        sb.note_item(rs);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic [39:0] rnd40();
        return 40'({$urandom(), $urandom()});
    endfunction

    task automatic random_setup(int mode);
        write_cfg(REG_INFECTION, (mode == 0) ? 40'hFF_FFFF_FFFF :
                  (mode == 1) ? 40'd0 : rnd40() >> $urandom_range(39));
        write_cfg(REG_RECOVERY, (mode == 0) ? 40'hFF_FFFF :
                  (mode == 1) ? 40'd0 : $urandom() >> $urandom_range(31, 8));
        write_cfg(REG_STEP, (mode == 0) ? 40'hFFFF_FFFF : (mode == 1) ? 40'd0 :
                  $urandom() >> $urandom_range(31, 12));
        write_cfg(REG_END, (mode == 0) ? 40'hFFFF_FFFF : (mode == 1) ? 40'd0 :
                  $urandom() >> $urandom_range(31, 8));
        write_cfg(REG_START_S, (mode == 0) ? 40'hFFFF_FFFF : (mode == 1) ? 40'd0 :
                  $urandom() >> $urandom_range(31));
        write_cfg(REG_START_I, (mode == 0) ? 40'hFFFF_FFFF : (mode == 1) ? 40'd0 :
                  $urandom() >> $urandom_range(31));
        write_cfg(REG_START_R, (mode == 0) ? 40'hFFFF_FFFF : (mode == 1) ? 40'd0 :
                  $urandom() >> $urandom_range(31));
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        send_item(0);
        send_item(1);
        drain();
        random_setup(0);
        send_item(1);
        repeat (3) send_item(0);
        drain();
        random_setup(1);
        send_item(0);
        send_item(1);
        send_item(0);
        drain();
        write_cfg(REG_INFECTION, 40'h00_0010_0000);
        write_cfg(REG_RECOVERY, 40'h00_4000);
        write_cfg(REG_STEP, 40'h0000_8000);
        write_cfg(REG_END, 40'h0002_0000);
        write_cfg(REG_START_S, 40'h0100_0000);
        write_cfg(REG_START_I, 40'h0001_0000);
        write_cfg(REG_START_R, 40'h0);
        write_cfg(REG_NONE, rnd40());
        send_item(1);
        repeat (7) send_item(0);
        drain();
        for (int ph = 0; ph < 14; ph++)
        begin
            random_setup(2);
            send_item(1);
            for (int k = 0; k < 30; k++)
                send_item($urandom_range(15) == 0);
            if (ph == 5)
            begin
                while (sb.pending.size() != 0) @(negedge clk);
                send_item(0);
            end
            drain();
        end
        drain();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        int wait_c;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (wait_c > 0)
            begin
                wait_c--;
                out_stall <= 1;
            end
            else
            begin
                out_stall <= 0;
                if (out_valid)
                    wait_c = ($urandom_range(3) == 0) ? 0 : $urandom_range(16);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_row({time_now, susceptible_now, infected_now, recovered_now,
                          final_row, clamped});

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

@@ sir_epidemic_rk4_step.f @@
design/sir_pkg.sv
design/sir_mul.sv
design/sir_div6.sv
design/sir_epidemic_rk4_step.sv
tb/tb_sir_epidemic_rk4_step.sv
